/* src/sincos_pkg.sv */
// Package for the sine/cosine block: constants, Horner coefficients and shared types.
// Used by every module in src; depends on nothing else.
package sincos_pkg;

   localparam int OUT_WIDTH        = 24;
   localparam int OUT_FRAC_BITS_DEF = 22;
   localparam int ANGLE_WIDTH      = 32;

   localparam int CELL_COUNT  = 5;
   localparam int FRONT_DEPTH = 9;
   localparam int CELL_DEPTH  = 4;
   localparam int BACK_DEPTH  = 7;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + CELL_COUNT * CELL_DEPTH + BACK_DEPTH;

   localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
   localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
   localparam logic [63:0] TWO_PI_Q61    = 64'hC90FDAA22168C235;
   localparam logic [22:0] OUT_MAG_MAX   = 23'h7FFFFF;

   localparam logic signed [63:0] ONE_Q62 = 64'sh4000000000000000;

   // starting accumulators (highest-order coefficients)
   localparam logic signed [63:0] COS_INIT = -64'sd1270857037706;
   localparam logic signed [63:0] SIN_INIT = -64'sd115532457973;

   // addend of each Horner cell, first cell first
   localparam logic signed [63:0] COS_STEP_K [CELL_COUNT] = '{
      64'sd114377133393536,
      -64'sd6405119470038039,
      64'sd192153584101141163,
      -64'sd2305843009213693952,
      ONE_Q62
   };

   localparam logic signed [63:0] SIN_STEP_K [CELL_COUNT] = '{
      64'sd12708570377060,
      -64'sd915017067148291,
      64'sd38430716820228233,
      -64'sd768614336404564651,
      64'sd0
   };

   typedef struct packed {
      logic use_sin;
      logic x_neg;
      logic sign;
      logic sign2;
   } flags_type;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] x2;
      flags_type   flags;
   } side_type;

endpackage

/* src/sine_cosine_polynomial.sv */
// Top level of the sine/cosine block: input channel, pipeline of Horner cells,
// output register with skid stage. Uses sincos_pkg and all sincos_* modules.
//
// req channel: req_valid/req_stall carry one angle (signed Q16.16 radians) per item.
// rsp channel: rsp_valid/rsp_stall carry sine and cosine (signed Q2.22 at the
// default OUT_FRAC_BITS) for each item, in order, one result per item.
// The accepting edge loads the first of 36 pipeline stages, and the output
// register follows the last of them; the pipeline is 9 reduction stages,
// five 4-stage Horner cells and 7 finishing stages.
// Throughput: one item per cycle while the skid register is empty, set by the
// fully pipelined 32x32 partial product multipliers.
// Reset clears the pipeline valid bits and the output and skid valid bits;
// items in flight are dropped. The data registers are not reset.
// While the receiver stalls, the pipeline keeps advancing until an item fills
// the skid register and then holds; req_stall is the skid register's valid bit,
// so it comes straight from a flop.
module sine_cosine_polynomial
   import sincos_pkg::*;
#(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_WIDTH-1:0]   rsp_sine,
   output logic signed [OUT_WIDTH-1:0]   rsp_cosine
);

   logic en;
   logic [PIPE_DEPTH-1:0] vld_in, vld_ff;

   side_type           side [CELL_COUNT+1];
   logic signed [63:0] acc_cos [CELL_COUNT+1];
   logic signed [63:0] acc_sin [CELL_COUNT+1];

   logic signed [OUT_WIDTH-1:0] pipe_sine, pipe_cosine;

   logic take, out_free, arrive;
   logic rsp_valid_in, rsp_valid_ff, skid_valid_in, skid_valid_ff;
   logic signed [OUT_WIDTH-1:0] rsp_sine_in, rsp_sine_ff, rsp_cosine_in, rsp_cosine_ff;
   logic signed [OUT_WIDTH-1:0] skid_sine_in, skid_sine_ff, skid_cosine_in, skid_cosine_ff;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   sincos_front u_front (
      .clock (clock),
      .en    (en),
      .angle (req_angle),
      .side  (side[0])
   );

   assign acc_cos[0] = COS_INIT;
   assign acc_sin[0] = SIN_INIT;

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      sincos_cell u_cell (
         .clock    (clock),
         .en       (en),
         .k_cos    (COS_STEP_K[g]),
         .k_sin    (SIN_STEP_K[g]),
         .in_cos   (acc_cos[g]),
         .in_sin   (acc_sin[g]),
         .in_side  (side[g]),
         .out_cos  (acc_cos[g+1]),
         .out_sin  (acc_sin[g+1]),
         .out_side (side[g+1])
      );
   end

   sincos_back #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .en      (en),
      .in_cos  (acc_cos[CELL_COUNT]),
      .in_sin  (acc_sin[CELL_COUNT]),
      .in_side (side[CELL_COUNT]),
      .sine    (pipe_sine),
      .cosine  (pipe_cosine)
   );

   assign take     = rsp_valid_ff & ~rsp_stall;
   assign out_free = ~rsp_valid_ff | take;
   assign arrive   = en & vld_ff[PIPE_DEPTH-1];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sine_in    = rsp_sine_ff;
      rsp_cosine_in  = rsp_cosine_ff;
      skid_valid_in  = skid_valid_ff;
      skid_sine_in   = skid_sine_ff;
      skid_cosine_in = skid_cosine_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_sine_in   = skid_sine_ff;
            rsp_cosine_in = skid_cosine_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_sine_in   = pipe_sine;
            rsp_cosine_in = pipe_cosine;
         end else begin
            skid_valid_in  = 1'b1;
            skid_sine_in   = pipe_sine;
            skid_cosine_in = pipe_cosine;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sine_ff    <= rsp_sine_in;
      rsp_cosine_ff  <= rsp_cosine_in;
      skid_sine_ff   <= skid_sine_in;
      skid_cosine_ff <= skid_cosine_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sine   = rsp_sine_ff;
   assign rsp_cosine = rsp_cosine_ff;

endmodule

/* src/sincos_mulhi.sv */
// High 64 bits of an unsigned 64x64 product, two pipeline stages.
// Four 32x32 partial products, then their sum. Uses sincos_pkg.
module sincos_mulhi
   import sincos_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] hi
);

   logic [63:0] p00_in, p01_in, p10_in, p11_in;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [33:0] mid;
   logic [63:0] hi_in, hi_ff;

   assign p00_in = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
   assign p01_in = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
   assign p10_in = {32'd0, a[63:32]} * {32'd0, b[31:0]};
   assign p11_in = {32'd0, a[63:32]} * {32'd0, b[63:32]};

   assign mid = {2'b00, p00_ff[63:32]} + {2'b00, p01_ff[31:0]} + {2'b00, p10_ff[31:0]};
   assign hi_in = p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]}
                  + {62'd0, mid[33:32]};

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         hi_ff  <= hi_in;
      end
   end

   assign hi = hi_ff;

endmodule

/* src/sincos_front.sv */
// Range reduction: |angle|/(2*pi), octant split, reduced angle x and x^2.
// Nine stages; uses sincos_pkg and sincos_mulhi.
module sincos_front
   import sincos_pkg::*;
(
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output side_type                      side
);

   logic [31:0] angle_u;
   logic        neg1_in;
   logic [31:0] mag1_in;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [31:0] mag1_ff;

   logic [63:0] ph2_in, plp;
   logic [31:0] pl2_in;
   logic [63:0] ph2_ff;
   logic [31:0] pl2_ff;

   logic [63:0] turns;
   logic [47:0] f3_in, f3_ff;

   logic [3:0]  s4_in, s4_ff;
   logic [48:0] xt4_in, xt4_ff;

   logic [48:0] ax_full;
   logic [2:0]  q5;
   logic [45:0] ax5_in, ax5_ff;
   flags_type   flags5_in, flags5_ff, flags6_ff, flags7_ff, flags8_ff, flags9_ff;

   logic [63:0] x7, x2_9;
   logic [63:0] x8_ff, x9_ff;

   assign angle_u = $unsigned(angle);
   assign neg1_in = angle_u[31];
   assign mag1_in = neg1_in ? (~angle_u + 32'd1) : angle_u;

   assign ph2_in = {32'd0, mag1_ff} * {32'd0, INV_TWO_PI_HI};
   assign plp    = {32'd0, mag1_ff} * {32'd0, INV_TWO_PI_LO};
   assign pl2_in = plp[63:32];

   assign turns = ph2_ff + {32'd0, pl2_ff};
   assign f3_in = turns[47:0];

   assign s4_in  = {1'b0, f3_ff[47:45]} + 4'd1;
   assign xt4_in = {1'b0, f3_ff} - {s4_in[3:1], 46'd0};

   assign ax_full = xt4_ff[48] ? (~xt4_ff + 49'd1) : xt4_ff;
   assign ax5_in  = ax_full[45:0];
   assign q5      = s4_ff[3:1];

   always_comb begin
      flags5_in.use_sin = ~q5[0];
      flags5_in.x_neg   = xt4_ff[48];
      flags5_in.sign    = ~s4_ff[2] ^ neg4_ff;
      flags5_in.sign2   = (s4_ff < 4'd2) || (s4_ff > 4'd5);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff   <= neg1_in;
         mag1_ff   <= mag1_in;
         neg2_ff   <= neg1_ff;
         ph2_ff    <= ph2_in;
         pl2_ff    <= pl2_in;
         neg3_ff   <= neg2_ff;
         f3_ff     <= f3_in;
         neg4_ff   <= neg3_ff;
         s4_ff     <= s4_in;
         xt4_ff    <= xt4_in;
         ax5_ff    <= ax5_in;
         flags5_ff <= flags5_in;
         flags6_ff <= flags5_ff;
         flags7_ff <= flags6_ff;
         flags8_ff <= flags7_ff;
         flags9_ff <= flags8_ff;
         x8_ff     <= x7;
         x9_ff     <= x8_ff;
      end
   end

   sincos_mulhi u_mul_x (
      .clock (clock),
      .en    (en),
      .a     ({ax5_ff, 18'd0}),
      .b     (TWO_PI_Q61),
      .hi    (x7)
   );

   sincos_mulhi u_mul_x2 (
      .clock (clock),
      .en    (en),
      .a     (x7),
      .b     (x7),
      .hi    (x2_9)
   );

   always_comb begin
      side.x     = x9_ff;
      side.x2    = x2_9;
      side.flags = flags9_ff;
   end

endmodule

/* src/sincos_cell.sv */
// One Horner step for both polynomials: acc = k + acc * x^2, toward zero.
// Four stages; uses sincos_pkg and sincos_mulhi.
module sincos_cell
   import sincos_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] k_cos,
   input  logic signed [63:0] k_sin,
   input  logic signed [63:0] in_cos,
   input  logic signed [63:0] in_sin,
   input  side_type           in_side,
   output logic signed [63:0] out_cos,
   output logic signed [63:0] out_sin,
   output side_type           out_side
);

   logic [63:0] cos_u, sin_u;
   logic [63:0] mag_c_in, mag_s_in, mag_c_ff, mag_s_ff;
   logic        neg_c1_ff, neg_c2_ff, neg_c3_ff;
   logic        neg_s1_ff, neg_s2_ff, neg_s3_ff;
   side_type    side1_ff, side2_ff, side3_ff, side4_ff;
   logic [63:0] hi_c, hi_s;
   logic signed [63:0] cos4_in, sin4_in, cos4_ff, sin4_ff;

   assign cos_u    = $unsigned(in_cos);
   assign sin_u    = $unsigned(in_sin);
   assign mag_c_in = cos_u[63] ? (~cos_u + 64'd1) : cos_u;
   assign mag_s_in = sin_u[63] ? (~sin_u + 64'd1) : sin_u;

   sincos_mulhi u_mul_c (
      .clock (clock),
      .en    (en),
      .a     (mag_c_ff),
      .b     (side1_ff.x2),
      .hi    (hi_c)
   );

   sincos_mulhi u_mul_s (
      .clock (clock),
      .en    (en),
      .a     (mag_s_ff),
      .b     (side1_ff.x2),
      .hi    (hi_s)
   );

   assign cos4_in = k_cos + (neg_c3_ff ? -$signed(hi_c) : $signed(hi_c));
   assign sin4_in = k_sin + (neg_s3_ff ? -$signed(hi_s) : $signed(hi_s));

   always_ff @(posedge clock) begin
      if (en) begin
         mag_c_ff  <= mag_c_in;
         mag_s_ff  <= mag_s_in;
         neg_c1_ff <= cos_u[63];
         neg_s1_ff <= sin_u[63];
         neg_c2_ff <= neg_c1_ff;
         neg_s2_ff <= neg_s1_ff;
         neg_c3_ff <= neg_c2_ff;
         neg_s3_ff <= neg_s2_ff;
         side1_ff  <= in_side;
         side2_ff  <= side1_ff;
         side3_ff  <= side2_ff;
         side4_ff  <= side3_ff;
         cos4_ff   <= cos4_in;
         sin4_ff   <= sin4_in;
      end
   end

   assign out_cos  = cos4_ff;
   assign out_sin  = sin4_ff;
   assign out_side = side4_ff;

endmodule

/* src/sincos_back.sv */
// Final sine term, octant output selection, rounding and saturation.
// Seven stages; uses sincos_pkg and sincos_mulhi.
module sincos_back
   import sincos_pkg::*;
#(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [63:0]          in_cos,
   input  logic signed [63:0]          in_sin,
   input  side_type                    in_side,
   output logic signed [OUT_WIDTH-1:0] sine,
   output logic signed [OUT_WIDTH-1:0] cosine
);

   localparam int          RND_SHIFT = 62 - OUT_FRAC_BITS;
   localparam logic [63:0] RND_HALF  = 64'd1 << (61 - OUT_FRAC_BITS);

   logic [63:0] t_u, mag_t_in, mag_t_ff;
   logic        neg_t1_ff, neg_t2_ff, neg_t3_ff;
   side_type    side1_ff, side2_ff, side3_ff;
   logic signed [63:0] cos1_ff, cos2_ff, cos3_ff, cos4_ff;
   logic [63:0] hi_t;
   logic signed [63:0] sin4_in, sin4_ff;
   flags_type   flags4_ff;

   logic signed [63:0] src_s, src_c;
   logic [63:0] src_s_u, src_c_u;
   logic        ctl_s, ctl_c;
   logic [63:0] mag_s5_in, mag_c5_in, mag_s5_ff, mag_c5_ff;
   logic        flip_s5_ff, flip_c5_ff, flip_s6_ff, flip_c6_ff;

   logic [63:0] rnd_s, rnd_c;
   logic [22:0] sat_s6_in, sat_c6_in, sat_s6_ff, sat_c6_ff;

   logic [OUT_WIDTH-1:0] sine7_in, cosine7_in, sine7_ff, cosine7_ff;

   assign t_u      = $unsigned(in_sin);
   assign mag_t_in = t_u[63] ? (~t_u + 64'd1) : t_u;

   sincos_mulhi u_mul_t (
      .clock (clock),
      .en    (en),
      .a     (mag_t_ff),
      .b     (side1_ff.x),
      .hi    (hi_t)
   );

   assign sin4_in = $signed({2'b00, side3_ff.x[63:2]})
                    + (neg_t3_ff ? -$signed(hi_t) : $signed(hi_t));

   always_comb begin
      if (flags4_ff.use_sin) begin
         src_s = sin4_ff;
         ctl_s = ~flags4_ff.sign ^ flags4_ff.x_neg;
         src_c = cos4_ff;
         ctl_c = ~flags4_ff.sign2;
      end else begin
         src_s = cos4_ff;
         ctl_s = ~flags4_ff.sign;
         src_c = sin4_ff;
         ctl_c = ~flags4_ff.sign2 ^ flags4_ff.x_neg;
      end
   end

   assign src_s_u   = $unsigned(src_s);
   assign src_c_u   = $unsigned(src_c);
   assign mag_s5_in = src_s_u[63] ? (~src_s_u + 64'd1) : src_s_u;
   assign mag_c5_in = src_c_u[63] ? (~src_c_u + 64'd1) : src_c_u;

   assign rnd_s = (mag_s5_ff + RND_HALF) >> RND_SHIFT;
   assign rnd_c = (mag_c5_ff + RND_HALF) >> RND_SHIFT;
   assign sat_s6_in = (rnd_s > {41'd0, OUT_MAG_MAX}) ? OUT_MAG_MAX : rnd_s[22:0];
   assign sat_c6_in = (rnd_c > {41'd0, OUT_MAG_MAX}) ? OUT_MAG_MAX : rnd_c[22:0];

   assign sine7_in   = flip_s6_ff ? (~{1'b0, sat_s6_ff} + 24'd1) : {1'b0, sat_s6_ff};
   assign cosine7_in = flip_c6_ff ? (~{1'b0, sat_c6_ff} + 24'd1) : {1'b0, sat_c6_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         mag_t_ff   <= mag_t_in;
         neg_t1_ff  <= t_u[63];
         neg_t2_ff  <= neg_t1_ff;
         neg_t3_ff  <= neg_t2_ff;
         side1_ff   <= in_side;
         side2_ff   <= side1_ff;
         side3_ff   <= side2_ff;
         cos1_ff    <= in_cos;
         cos2_ff    <= cos1_ff;
         cos3_ff    <= cos2_ff;
         cos4_ff    <= cos3_ff;
         sin4_ff    <= sin4_in;
         flags4_ff  <= side3_ff.flags;
         mag_s5_ff  <= mag_s5_in;
         mag_c5_ff  <= mag_c5_in;
         flip_s5_ff <= src_s_u[63] ^ ctl_s;
         flip_c5_ff <= src_c_u[63] ^ ctl_c;
         flip_s6_ff <= flip_s5_ff;
         flip_c6_ff <= flip_c5_ff;
         sat_s6_ff  <= sat_s6_in;
         sat_c6_ff  <= sat_c6_in;
         sine7_ff   <= sine7_in;
         cosine7_ff <= cosine7_in;
      end
   end

   assign sine   = $signed(sine7_ff);
   assign cosine = $signed(cosine7_ff);

endmodule

/* tb/sv/tb_sine_cosine_polynomial.sv */
// Testbench for sine_cosine_polynomial: drives angles through valid/stall, predicts each
// sine/cosine pair in bit-exact fixed point and checks results in order.
// Depends on sincos_pkg and the sine_cosine_polynomial RTL only.
module tb_sine_cosine_polynomial;
   import sincos_pkg::*;

   localparam int FRAC = OUT_FRAC_BITS_DEF;
   localparam int PIPE_PAD = 45;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int TWO_PI_Q16 = 411775;
   localparam real QUARTER_PI_Q16 = 51471.8540558;

   localparam logic [63:0] RECIP_HI = 64'h28BE60DB;
   localparam logic [63:0] RECIP_LO = 64'h9391054A;
   localparam logic [63:0] TURN_Q61 = 64'hC90FDAA22168C235;
   localparam logic signed [63:0] UNIT_Q62 = 64'sh4000000000000000;

   // Horner coefficients, lowest order first
   localparam logic signed [63:0] COS_HORNER [5] = '{
      -64'sd2305843009213693952, 64'sd192153584101141163, -64'sd6405119470038039,
      64'sd114377133393536, -64'sd1270857037706
   };
   localparam logic signed [63:0] SIN_HORNER [5] = '{
      -64'sd768614336404564651, 64'sd38430716820228233, -64'sd915017067148291,
      64'sd12708570377060, -64'sd115532457973
   };

   typedef struct {
      logic [ANGLE_WIDTH-1:0] angle;
      logic [OUT_WIDTH-1:0]   sine;
      logic [OUT_WIDTH-1:0]   cosine;
   } trig_pair_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [ANGLE_WIDTH-1:0] req_angle = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [OUT_WIDTH-1:0]   rsp_sine;
   logic signed [OUT_WIDTH-1:0]   rsp_cosine;

   trig_pair_type sincos_expected [$];
   int  mismatches = 0;
   int  angles_sent = 0;
   int  pairs_checked = 0;
   int  input_stall_cycles = 0;
   int  quiet_cycles = 0;
   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   int  hold_id = 0;
   int  hold_seen = 0;
   int  hold_left = 0;

   sine_cosine_polynomial DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sine   (rsp_sine),
      .rsp_cosine (rsp_cosine)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] hi_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
   endfunction

   // magnitude product, sign restored afterwards (truncates toward zero)
   function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                         logic [63:0] b);
      logic [63:0] m;
      logic [63:0] r;
      m = a[63] ? (64'd0 - a) : a;
      r = hi_product(m, b);
      return a[63] ? (64'd0 - r) : r;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] round_out(logic signed [63:0] v, logic negate);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
      if (m > 64'h7FFFFF) m = 64'h7FFFFF;
      if (v[63] != negate) m = 64'd0 - m;
      return m[OUT_WIDTH-1:0];
   endfunction

   function automatic trig_pair_type predict_sincos(logic [ANGLE_WIDTH-1:0] ang);
      trig_pair_type res;
      logic neg_angle, x_neg, sgn, sgn2, use_sin;
      logic [63:0] mag, turns, frac, ax, x, x2;
      logic [3:0] oct;
      logic [2:0] quad;
      logic signed [63:0] xt, rc, rs, cosv, sinv, t;
      int i;
      res.angle = ang;
      neg_angle = ang[31];
      mag = neg_angle ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
      turns = mag * RECIP_HI + ((mag * RECIP_LO) >> 32);
      frac = {16'd0, turns[47:0]};
      oct = {1'b0, frac[47:45]} + 4'd1;
      quad = oct[3:1];
      xt = frac - ({61'd0, quad} << 46);
      x_neg = xt[63];
      ax = x_neg ? (64'd0 - xt) : xt;
      x = hi_product(ax << 18, TURN_Q61);
      x2 = hi_product(x, x);
      rc = COS_HORNER[4];
      rs = SIN_HORNER[4];
      for (i = 3; i >= 0; i--) begin
         rc = COS_HORNER[i] + scaled_product(rc, x2);
         rs = SIN_HORNER[i] + scaled_product(rs, x2);
      end
      cosv = UNIT_Q62 + scaled_product(rc, x2);
      t = scaled_product(rs, x2);
      sinv = signed'({2'b00, x[63:2]}) + scaled_product(t, x);
      sgn = (oct[2] == 1'b0) ^ neg_angle;
      sgn2 = (oct < 4'd2) || (oct > 4'd5);
      use_sin = !quad[0];
      if (use_sin) begin
         res.sine = round_out(sinv, (!sgn) != x_neg);
         res.cosine = round_out(cosv, !sgn2);
      end else begin
         res.sine = round_out(cosv, !sgn);
         res.cosine = round_out(sinv, (!sgn2) != x_neg);
      end
      return res;
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] random_angle();
      int kind;
      int k;
      logic [ANGLE_WIDTH-1:0] v;
      kind = $urandom_range(9);
      if (kind < 3) begin
         v = $urandom;
      end else if (kind < 6) begin
         v = $urandom_range(0, 2 * TWO_PI_Q16) - TWO_PI_Q16;
      end else if (kind < 8) begin
         // near an octant boundary
         k = int'($urandom_range(0, 80)) - 40;
         v = int'(real'(k) * QUARTER_PI_Q16) + int'($urandom_range(0, 6)) - 3;
      end else if (kind == 8) begin
         v = int'($urandom_range(0, 511)) - 256;
      end else begin
         v = $urandom_range(1) ? (32'h7FFFFFFF - $urandom_range(255))
                               : (32'h80000000 + $urandom_range(255));
      end
      return v;
   endfunction

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_id != hold_seen) begin
         hold_seen <= hold_id;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      trig_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sincos_expected.size() == 0) begin
            $display("%0t unexpected item: sine %h cosine %h", $time, rsp_sine, rsp_cosine);
            mismatches++;
         end else begin
            want = sincos_expected.pop_front();
            if (rsp_sine !== want.sine) begin
               $display("%0t angle %h sine: expected %h actual %h",
                        $time, want.angle, want.sine, rsp_sine);
               mismatches++;
            end
            if (rsp_cosine !== want.cosine) begin
               $display("%0t angle %h cosine: expected %h actual %h",
                        $time, want.angle, want.cosine, rsp_cosine);
               mismatches++;
            end
            pairs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t timeout: no item moved for %0d cycles, %0d pending",
                  $time, quiet_cycles, sincos_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_angle(logic [ANGLE_WIDTH-1:0] ang);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_angle <= ang;
      do @(posedge clock); while (req_stall);
      sincos_expected.push_back(predict_sincos(ang));
      angles_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sincos_expected.size() != 0) @(posedge clock);
      repeat (PIPE_PAD) @(posedge clock);
   endtask

   task automatic run_random(int count, int tx_pct, int rx_pct);
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (count) send_angle(random_angle());
      drain();
   endtask

   task automatic test_directed();
      logic signed [ANGLE_WIDTH-1:0] angles [22] = '{
         32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
         32'sd51471, 32'sd51472, 32'sd102943, 32'sd102944, 32'sd205887, 32'sd205888,
         32'sd308831, 32'sd308832, 32'sd411774, 32'sd411775, -32'sd51472,
         -32'sd102944, -32'sd205887, 32'sh00010000, 32'sh55555555, 32'shAAAAAAAA
      };
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      foreach (angles[i]) send_angle(angles[i]);
      drain();
   endtask

   task automatic test_no_idle();
      run_random(120, 0, 0);
   endtask

   task automatic test_sender_idle();
      run_random(120, 62, 0);
   endtask

   task automatic test_receiver_stall();
      run_random(120, 0, 62);
   endtask

   task automatic test_both_idle();
      run_random(120, 17, 17);
   endtask

   // receiver holds off while the sender keeps offering, so the pipeline fills
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_id++;
      repeat (60) send_angle(random_angle());
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      $display("%0d angles sent (octant edges, range extremes, random), %0d pairs checked",
               angles_sent, pairs_checked);
      $display("idle and stall phases plus a %0d-cycle receiver hold-off; input stalled %0d cycles",
               HOLD_CYCLES, input_stall_cycles);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sine_cosine_polynomial.f */
src/sincos_pkg.sv
src/sincos_mulhi.sv
src/sincos_front.sv
src/sincos_cell.sv
src/sincos_back.sv
src/sine_cosine_polynomial.sv
tb/sv/tb_sine_cosine_polynomial.sv
